// File: rtl/hdcp_seq_pkg.sv
// Shared types, codes and helpers for the HDCP authentication sequencer.
package hdcp_seq_pkg;

  // Event codes
  localparam logic [3:0] EV_ENABLE      = 4'd0;
  localparam logic [3:0] EV_DISABLE     = 4'd1;
  localparam logic [3:0] EV_FRAME_START = 4'd2;
  localparam logic [3:0] EV_FRAME_STOP  = 4'd3;
  localparam logic [3:0] EV_HPD_LOW     = 4'd4;
  localparam logic [3:0] EV_REAUTH      = 4'd5;
  localparam logic [3:0] EV_R0          = 4'd6;
  localparam logic [3:0] EV_KSV_READY   = 4'd7;
  localparam logic [3:0] EV_KSV_TIMEOUT = 4'd8;
  localparam logic [3:0] EV_RI_FAIL     = 4'd9;

  // Engine step status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_AKSV   = 2'd1;
  localparam logic [1:0] ST_CANCEL = 2'd2;
  localparam logic [1:0] ST_OTHER  = 2'd3;

  // Authentication status codes
  localparam logic [2:0] AUTH_OFF        = 3'd0;
  localparam logic [2:0] AUTH_STEP1      = 3'd1;
  localparam logic [2:0] AUTH_STEP2      = 3'd2;
  localparam logic [2:0] AUTH_DONE       = 3'd3;
  localparam logic [2:0] AUTH_RESTARTING = 3'd4;
  localparam logic [2:0] AUTH_FAILED     = 3'd5;

  // Timer commands
  localparam logic [2:0] TMR_KEEP      = 3'd0;
  localparam logic [2:0] TMR_CANCEL    = 3'd1;
  localparam logic [2:0] TMR_R0        = 3'd2;
  localparam logic [2:0] TMR_KSV       = 3'd3;
  localparam logic [2:0] TMR_REAUTH    = 3'd4;

  // Link state codes as seen on the result
  localparam logic [2:0] LS_DISABLED = 3'd0;
  localparam logic [2:0] LS_PENDING  = 3'd1;
  localparam logic [2:0] LS_START    = 3'd2;
  localparam logic [2:0] LS_WAIT_R0  = 3'd3;
  localparam logic [2:0] LS_WAIT_KSV = 3'd4;
  localparam logic [2:0] LS_CHECK    = 3'd5;

  // Register indexes
  localparam logic CFG_MAX_RETRIES = 1'b0;
  localparam logic CFG_DDC_LIMIT   = 1'b1;

  localparam logic [7:0] DDC_LIMIT_RESET = 8'd5;

  typedef enum logic [5:0] {
    LINK_DISABLED = 6'b000001,
    LINK_PENDING  = 6'b000010,
    LINK_START    = 6'b000100,
    LINK_WAIT_R0  = 6'b001000,
    LINK_WAIT_KSV = 6'b010000,
    LINK_CHECK    = 6'b100000
  } link_t;

  typedef struct packed {
    logic [3:0] event_req;
    logic       hotplug_lost;
    logic       key_ok;
    logic [1:0] step_status;
    logic       is_repeater;
    logic [7:0] ddc_error_count;
  } item_t;

  typedef struct packed {
    link_t      link_mode;
    logic [2:0] auth_progress;
    logic       video_running;
    logic [7:0] retry_count;
    logic       retry_unlimited;
  } state_t;

  typedef struct packed {
    logic [2:0] link_state;
    logic [2:0] auth_status;
    logic [2:0] timer_command;
    logic       engine_disable;
    logic       restart_link;
    logic       mute_encryption_off;
    logic       stop_acknowledge;
    logic       clear_ddc_errors;
    logic [7:0] retries_left;
    logic       retry_forever;
  } result_t;

  function automatic logic [2:0] link_code(input link_t l);
    logic [2:0] c;
    begin
      unique case (l)
        LINK_DISABLED: c = LS_DISABLED;
        LINK_PENDING:  c = LS_PENDING;
        LINK_START:    c = LS_START;
        LINK_WAIT_R0:  c = LS_WAIT_R0;
        LINK_WAIT_KSV: c = LS_WAIT_KSV;
        LINK_CHECK:    c = LS_CHECK;
        default:       c = LS_DISABLED;
      endcase
      return c;
    end
  endfunction

endpackage

// File: rtl/hdcp_seq_if.sv
// Valid/ready channel interfaces for sequencer events and results.
interface hdcp_seq_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_req;
  logic       hotplug_lost;
  logic       key_ok;
  logic [1:0] step_status;
  logic       is_repeater;
  logic [7:0] ddc_error_count;

  modport source (
    output valid, event_req, hotplug_lost, key_ok, step_status, is_repeater,
           ddc_error_count,
    input  ready
  );
  modport sink (
    input  valid, event_req, hotplug_lost, key_ok, step_status, is_repeater,
           ddc_error_count,
    output ready
  );
endinterface

interface hdcp_seq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] link_state;
  logic [2:0] auth_status;
  logic [2:0] timer_command;
  logic       engine_disable;
  logic       restart_link;
  logic       mute_encryption_off;
  logic       stop_acknowledge;
  logic       clear_ddc_errors;
  logic [7:0] retries_left;
  logic       retry_forever;

  modport source (
    output valid, link_state, auth_status, timer_command, engine_disable,
           restart_link, mute_encryption_off, stop_acknowledge, clear_ddc_errors,
           retries_left, retry_forever,
    input  ready
  );
  modport sink (
    input  valid, link_state, auth_status, timer_command, engine_disable,
           restart_link, mute_encryption_off, stop_acknowledge, clear_ddc_errors,
           retries_left, retry_forever,
    output ready
  );
endinterface

// File: rtl/hdcp_seq_in_stage.sv
// Input register stage: captures one event item, holds it while the result side stalls.
module hdcp_seq_in_stage
  import hdcp_seq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  hdcp_seq_in_if.sink       req,
  input  logic              advance,
  output logic              item_valid,
  output item_t             item
);

  assign req.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item.event_req       <= req.event_req;
      item.hotplug_lost    <= req.hotplug_lost;
      item.key_ok          <= req.key_ok;
      item.step_status     <= req.step_status;
      item.is_repeater     <= req.is_repeater;
      item.ddc_error_count <= req.ddc_error_count;
    end
  end

endmodule

// File: rtl/hdcp_seq_decode.sv
// Next-state and action decode for one event against the current sequencer state.
module hdcp_seq_decode
  import hdcp_seq_pkg::*;
(
  input  item_t      item,
  input  state_t     cur,
  input  logic [7:0] max_retries,
  input  logic [7:0] ddc_error_limit,
  output state_t     nxt,
  output result_t    res
);

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_START = 3'd1,
    ACT_R0    = 3'd2,
    ACT_STEP2 = 3'd3,
    ACT_FAIL  = 3'd4
  } act_t;

  act_t       act;
  link_t      lm;
  logic [2:0] ap;
  logic       vr;
  logic [7:0] rc;
  logic       ru;
  logic [2:0] timer;
  logic       eng_dis;
  logic       restart;
  logic       mute;
  logic       stop_ack;
  logic       clr_ddc;
  logic       go_fail;
  logic       go_restart;
  logic       avail;
  logic       timer_ev;

  always_comb begin
    lm         = cur.link_mode;
    ap         = cur.auth_progress;
    vr         = cur.video_running;
    rc         = cur.retry_count;
    ru         = cur.retry_unlimited;
    timer      = TMR_KEEP;
    eng_dis    = 1'b0;
    restart    = 1'b0;
    mute       = 1'b0;
    stop_ack   = 1'b0;
    clr_ddc    = 1'b0;
    go_fail    = 1'b0;
    go_restart = 1'b0;
    avail      = 1'b0;
    act        = ACT_NONE;
    timer_ev   = (item.event_req == EV_REAUTH) || (item.event_req == EV_R0) ||
                 (item.event_req == EV_KSV_TIMEOUT);

    if (item.hotplug_lost) begin
      timer = TMR_CANCEL;
    end

    if (item.event_req == EV_FRAME_START) begin
      vr = 1'b1;
    end else if (item.event_req == EV_FRAME_STOP) begin
      vr = 1'b0;
    end

    // teardown events
    if (item.event_req == EV_DISABLE || item.event_req == EV_FRAME_STOP ||
        item.event_req == EV_HPD_LOW) begin
      if (lm != LINK_DISABLED) begin
        timer   = TMR_CANCEL;
        eng_dis = 1'b1;
        lm      = (item.event_req == EV_DISABLE) ? LINK_DISABLED : LINK_PENDING;
        ap      = AUTH_OFF;
      end
      if (item.event_req == EV_FRAME_STOP) begin
        stop_ack = 1'b1;
      end
    end

    // timer events are dropped once hot-plug is lost
    if (!(item.hotplug_lost && timer_ev)) begin
      unique case (lm)
        LINK_DISABLED: begin
          if (item.event_req == EV_ENABLE) begin
            ru = (max_retries == 8'd0);
            rc = max_retries;
            if (vr) begin
              act = ACT_START;
            end else begin
              lm = LINK_PENDING;
            end
          end
        end
        LINK_PENDING: begin
          if (item.event_req == EV_FRAME_START) act = ACT_START;
        end
        LINK_START: begin
          if (item.event_req == EV_REAUTH) act = ACT_START;
        end
        LINK_WAIT_R0: begin
          if (item.event_req == EV_R0) act = ACT_R0;
        end
        LINK_WAIT_KSV: begin
          if (item.event_req == EV_RI_FAIL || item.event_req == EV_KSV_TIMEOUT) begin
            act = ACT_FAIL;
          end else if (item.event_req == EV_KSV_READY) begin
            act = ACT_STEP2;
          end
        end
        LINK_CHECK: begin
          if (item.event_req == EV_RI_FAIL) act = ACT_FAIL;
        end
        default: ;
      endcase
    end

    unique case (act)
      ACT_START: begin
        lm = LINK_START;
        if (!item.key_ok) begin
          go_fail = 1'b1;
        end else if (item.step_status == ST_AKSV) begin
          go_restart = 1'b1;
        end else if (item.step_status == ST_OTHER) begin
          go_fail = 1'b1;
        end else if (item.step_status == ST_OK) begin
          lm    = LINK_WAIT_R0;
          ap    = AUTH_STEP1;
          timer = TMR_R0;
        end
      end
      ACT_R0: begin
        if (item.step_status == ST_CANCEL) begin
          // cancelled: hold state
        end else if (item.step_status != ST_OK) begin
          go_fail = 1'b1;
        end else if (item.is_repeater) begin
          lm    = LINK_WAIT_KSV;
          ap    = AUTH_STEP2;
          timer = TMR_KSV;
        end else begin
          lm = LINK_CHECK;
          ap = AUTH_DONE;
          ru = (max_retries == 8'd0);
          rc = max_retries;
        end
      end
      ACT_STEP2: begin
        timer = TMR_CANCEL;
        if (item.step_status == ST_CANCEL) begin
          // cancelled: hold state
        end else if (item.step_status != ST_OK) begin
          go_fail = 1'b1;
        end else begin
          lm = LINK_CHECK;
          ap = AUTH_DONE;
          ru = (max_retries == 8'd0);
          rc = max_retries;
        end
      end
      ACT_FAIL: go_fail = 1'b1;
      default: ;
    endcase

    // authentication failure: too many DDC errors escalates to a link restart
    if (go_fail) begin
      if (item.ddc_error_count >= ddc_error_limit) begin
        clr_ddc    = 1'b1;
        go_restart = 1'b1;
      end else begin
        mute    = 1'b1;
        eng_dis = 1'b1;
        timer   = TMR_CANCEL;
        avail   = ru || (rc != 8'd0);
        if (!ru && rc != 8'd0) rc = rc - 8'd1;
        if (avail) begin
          lm    = LINK_START;
          ap    = AUTH_RESTARTING;
          timer = TMR_REAUTH;
        end else begin
          lm = LINK_DISABLED;
          ap = AUTH_FAILED;
        end
      end
    end

    if (go_restart) begin
      timer   = TMR_CANCEL;
      eng_dis = 1'b1;
      avail   = ru || (rc != 8'd0);
      if (!ru && rc != 8'd0) rc = rc - 8'd1;
      if (avail) begin
        restart = 1'b1;
        lm      = LINK_PENDING;
        ap      = AUTH_RESTARTING;
      end else begin
        lm = LINK_DISABLED;
        ap = AUTH_FAILED;
      end
    end
  end

  assign nxt.link_mode       = lm;
  assign nxt.auth_progress   = ap;
  assign nxt.video_running   = vr;
  assign nxt.retry_count     = rc;
  assign nxt.retry_unlimited = ru;

  assign res.link_state          = link_code(lm);
  assign res.auth_status         = ap;
  assign res.timer_command       = timer;
  assign res.engine_disable      = eng_dis;
  assign res.restart_link        = restart;
  assign res.mute_encryption_off = mute;
  assign res.stop_acknowledge    = stop_ack;
  assign res.clear_ddc_errors    = clr_ddc;
  assign res.retries_left        = ru ? 8'd0 : rc;
  assign res.retry_forever       = ru;

endmodule

// File: rtl/hdcp_authentication_sequencer.sv
// Top level of the HDCP authentication sequencer: state, config and result register.
// Path: an accepted event goes through the input register, the decode and then the result register.
// Throughput: one event per cycle, back to back, while the result is read; one decode sits between the two registers.
// Stalls: input ready drops only while both registers hold items and the result is not read.
// Reset (rst, synchronous, high): link disabled, auth disabled, video stopped, retries zero,
// max_retries = 0, ddc_error_limit = 5, both channels empty.
module hdcp_authentication_sequencer
  import hdcp_seq_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  hdcp_seq_in_if.sink   req,
  hdcp_seq_out_if.source rsp
);

  // Configuration registers
  logic [7:0] max_retries;
  logic [7:0] ddc_error_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_retries     <= 8'd0;
      ddc_error_limit <= DDC_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_RETRIES: max_retries     <= cfg_data;
        CFG_DDC_LIMIT:   ddc_error_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: the result register frees up when empty or being read
  logic    out_valid;
  logic    advance;
  logic    item_valid;
  item_t   item;
  state_t  state;
  state_t  state_next;
  result_t res_next;
  result_t res;

  assign advance = !out_valid || rsp.ready;

  hdcp_seq_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  hdcp_seq_decode u_decode (
    .item            (item),
    .cur             (state),
    .max_retries     (max_retries),
    .ddc_error_limit (ddc_error_limit),
    .nxt             (state_next),
    .res             (res_next)
  );

  // Sequencer state: committed together with the result it produced
  always_ff @(posedge clk) begin
    if (rst) begin
      state.link_mode       <= LINK_DISABLED;
      state.auth_progress   <= AUTH_OFF;
      state.video_running   <= 1'b0;
      state.retry_count     <= 8'd0;
      state.retry_unlimited <= 1'b0;
    end else if (item_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_valid && advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res <= res_next;
    end
  end

  assign rsp.valid               = out_valid;
  assign rsp.link_state          = res.link_state;
  assign rsp.auth_status         = res.auth_status;
  assign rsp.timer_command       = res.timer_command;
  assign rsp.engine_disable      = res.engine_disable;
  assign rsp.restart_link        = res.restart_link;
  assign rsp.mute_encryption_off = res.mute_encryption_off;
  assign rsp.stop_acknowledge    = res.stop_acknowledge;
  assign rsp.clear_ddc_errors    = res.clear_ddc_errors;
  assign rsp.retries_left        = res.retries_left;
  assign rsp.retry_forever       = res.retry_forever;

`ifndef SYNTHESIS
  // Authenticated status and link-check state always travel together
  a_auth_link_pair: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((rsp.auth_status == AUTH_DONE) == (rsp.link_state == LS_CHECK)))
    else $error("auth_status and link_state disagree on authenticated");

  // A link restart always disables the engine and leaves the link pending
  a_restart_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.restart_link) |->
      (rsp.engine_disable && rsp.link_state == LS_PENDING &&
       rsp.auth_status == AUTH_RESTARTING))
    else $error("restart_link without matching state");

  // With an empty result register the input side must be open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("input stalled with empty result register");

  // Infinite retry budget reports zero retries left
  a_forever_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.retry_forever) |-> (rsp.retries_left == 8'd0))
    else $error("retries_left nonzero while retrying forever");
`endif

endmodule
